/* design/tpct_pkg.sv */
`timescale 1ns / 1ps

package tpct_pkg;

    // Sizing
    localparam int NUM_TRANSITIONS = 256;
    localparam int NUM_PATHS       = 16;
    localparam int PATH_LENGTH     = 16;
    localparam int COUNT_BITS      = 32;

    localparam int TRANS_W = $clog2(NUM_TRANSITIONS);
    localparam int PATH_W  = $clog2(NUM_PATHS);
    localparam int POS_W   = $clog2(PATH_LENGTH);
    localparam int FILL_W  = $clog2(NUM_PATHS + 1);
    localparam int BPOS_W  = $clog2(PATH_LENGTH + 1);
    localparam int LIST_AW = TRANS_W + PATH_W;
    localparam int ELEM_AW = PATH_W + POS_W;

    // Word field widths
    localparam int CMD_W  = 3;
    localparam int TRN_W  = 8;
    localparam int PIDX_W = 4;
    localparam int STAT_W = 2;
    localparam int PNUM_W = 4;
    localparam int CVAL_W = 32;
    localparam int DONE_W = 5;

    localparam logic [DONE_W-1:0] DONE_MAX = '1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_EVENT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RD_CNT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RD_TRAV = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_INACTIVE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd3;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TRN_W-1:0]  transition;
        logic              last_element;
        logic [PIDX_W-1:0] path_index;
    } in_word_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PNUM_W-1:0] path_number;
        logic [CVAL_W-1:0] count_value;
        logic [DONE_W-1:0] paths_completed;
    } out_word_t;

    // Outcome of checking one path against an event
    typedef struct packed {
        logic             prog_we;
        logic             completed;
        logic [POS_W-1:0] prog_next;
    } step_res_t;

endpackage

/* design/tpct_sat_inc.sv */
`timescale 1ns / 1ps

module tpct_sat_inc (
    input  tpct_pkg::count_t a,
    output tpct_pkg::count_t y
);
    import tpct_pkg::*;

    // Increment, holding at all ones
    assign y = (&a) ? a : a + 1'b1;

endmodule

/* design/tpct_step_unit.sv */
`timescale 1ns / 1ps

module tpct_step_unit (
    input  logic [tpct_pkg::TRN_W-1:0] transition,
    input  logic [tpct_pkg::TRN_W-1:0] elem_at_pos,
    input  logic [tpct_pkg::TRN_W-1:0] elem_first,
    input  logic [tpct_pkg::POS_W-1:0] pos,
    input  logic [tpct_pkg::POS_W-1:0] final_pos,
    output tpct_pkg::step_res_t        res
);
    import tpct_pkg::*;

    // Advance on expected element (at the final one: complete, back to 0), restart on first element, else hold
    always_comb begin
        res = '0;
        if (elem_at_pos == transition) begin
            res.prog_we = 1'b1;
            if (pos == final_pos) begin
                res.completed = 1'b1;
                res.prog_next = '0;
            end else begin
                res.prog_next = pos + 1'b1;
            end
        end else if (elem_first == transition) begin
            res.prog_we   = 1'b1;
            res.prog_next = POS_W'(1);
        end
    end

endmodule

/* design/transition_path_coverage_tracker_unit.sv */
`timescale 1ns / 1ps

// Transition path coverage tracker.
// Input channel s_valid/s_ready/s_word carries one command word; every word
// gives exactly one result word on m_valid/m_ready/m_word. Config channel
// cfg_valid/cfg_ready/cfg_wdata writes the active bit; it is always ready.
// Each word passes from accept through a count update state to a done
// state and then into the output register. A transition event also walks
// that transition's path list (fill up to 16) in between: each listed path
// costs one list-memory read and one path-element read through a single
// step unit, and listed paths not yet closed are skipped without the
// element read. s_ready is high only while no word is in work, so one word
// is processed at a time.
// The result sits in an output register: a new word is accepted while the
// previous result waits for m_ready, and a stalled receiver holds the block
// only when a second result is finished and has nowhere to go.
// Reset (aresetn low, synchronous) clears counts, list fills, path progress,
// traversal counts and the path table, and drops the active bit.
module transition_path_coverage_tracker_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tpct_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output tpct_pkg::out_word_t m_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_wdata
);
    import tpct_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_CNT_UPD = 5'b00010,
        S_LST_CHK = 5'b00100,
        S_ELM_CHK = 5'b01000,
        S_DONE    = 5'b10000
    } state_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        count_t            count;
    } cnt_entry_t;

    // Control state
    state_t            state_reg, state_next;
    logic              active_reg;
    logic              m_valid_reg, m_valid_next;
    logic [FILL_W-1:0] i_reg, i_next;
    logic [FILL_W-1:0] n_reg, n_next;
    logic [FILL_W-1:0] pdef_reg, pdef_next;
    logic [BPOS_W-1:0] bpos_reg, bpos_next;
    logic [POS_W-1:0]  prog_reg [NUM_PATHS];
    count_t            trav_reg [NUM_PATHS];
    logic              cnt_vld_reg [NUM_TRANSITIONS];

    // Payload
    in_word_t          word_reg;
    out_word_t         res_reg, res_next;
    out_word_t         m_word_reg;
    logic [PATH_W-1:0] p_reg, p_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  final_reg [NUM_PATHS];

    // Memories
    cnt_entry_t        cnt_mem [NUM_TRANSITIONS];
    logic [PATH_W-1:0] list_mem [NUM_TRANSITIONS * NUM_PATHS];
    logic [TRN_W-1:0]  elem_mem [NUM_PATHS * PATH_LENGTH];
    cnt_entry_t        cnt_rdata_reg;
    logic              cnt_rvld_reg;
    logic [PATH_W-1:0] list_rdata_reg;
    logic [TRN_W-1:0]  elem_pos_rdata_reg, elem_first_rdata_reg;

    // Memory and register file controls
    logic               accept, out_load, clear_all;
    logic               cnt_we;
    logic [TRANS_W-1:0] cnt_raddr, cnt_waddr;
    cnt_entry_t         cnt_wdata;
    logic               list_re, list_we;
    logic [LIST_AW-1:0] list_raddr, list_waddr;
    logic [PATH_W-1:0]  list_wdata;
    logic               elem_re, elem_we;
    logic [ELEM_AW-1:0] elem_raddr0, elem_raddr1, elem_waddr;
    logic [TRN_W-1:0]   elem_wdata;
    logic               prog_we;
    logic [PATH_W-1:0]  prog_waddr;
    logic [POS_W-1:0]   prog_wdata;
    logic               trav_we;
    logic               final_we;
    logic [PATH_W-1:0]  final_waddr;
    logic [POS_W-1:0]   final_wdata;

    // Datapath helpers
    cnt_entry_t         cnt_word;
    logic               t_ok;
    logic [TRANS_W-1:0] t_idx;
    logic [PATH_W-1:0]  trav_addr;
    count_t             trav_rd, inc_in, inc_out;
    logic               lst_live, more;
    logic [POS_W-1:0]   prog_cur, pos_clamp;
    logic [FILL_W-1:0]  i_inc;
    logic [PATH_W-1:0]  pnum;
    logic [BPOS_W-1:0]  bp_new;
    step_res_t          step;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_word    = m_word_reg;
    assign cfg_ready = 1'b1;

    assign cnt_word  = cnt_rvld_reg ? cnt_rdata_reg : '0;
    assign t_ok      = 32'(word_reg.transition) < NUM_TRANSITIONS;
    assign t_idx     = word_reg.transition[TRANS_W-1:0];
    assign trav_addr = (state_reg == S_ELM_CHK) ? p_reg : word_reg.path_index[PATH_W-1:0];
    assign trav_rd   = trav_reg[trav_addr];
    assign inc_in    = (state_reg == S_ELM_CHK) ? trav_rd : cnt_word.count;
    assign lst_live  = FILL_W'(list_rdata_reg) < pdef_reg;
    assign prog_cur  = prog_reg[list_rdata_reg];
    assign pos_clamp = (32'(prog_cur) < PATH_LENGTH) ? prog_cur : '0;
    assign i_inc     = i_reg + 1'b1;
    assign more      = i_inc < n_reg;
    assign pnum      = pdef_reg[PATH_W-1:0];
    assign cnt_raddr = s_word.transition[TRANS_W-1:0];

    // Shared saturating incrementer: transition counts and traversals
    tpct_sat_inc u_sat_inc (
        .a (inc_in),
        .y (inc_out)
    );

    // Path match check for the list entry in hand
    tpct_step_unit u_step (
        .transition  (word_reg.transition),
        .elem_at_pos (elem_pos_rdata_reg),
        .elem_first  (elem_first_rdata_reg),
        .pos         (pos_reg),
        .final_pos   (final_reg[p_reg]),
        .res         (step)
    );

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        n_next       = n_reg;
        p_next       = p_reg;
        pos_next     = pos_reg;
        pdef_next    = pdef_reg;
        bpos_next    = bpos_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_load     = 1'b0;
        clear_all    = 1'b0;
        cnt_we       = 1'b0;
        cnt_waddr    = t_idx;
        cnt_wdata    = cnt_word;
        list_re      = 1'b0;
        list_raddr   = {t_idx, i_inc[PATH_W-1:0]};
        list_we      = 1'b0;
        list_waddr   = {t_idx, cnt_word.fill[PATH_W-1:0]};
        list_wdata   = pnum;
        elem_re      = 1'b0;
        elem_raddr0  = {list_rdata_reg, pos_clamp};
        elem_raddr1  = {list_rdata_reg, {POS_W{1'b0}}};
        elem_we      = 1'b0;
        elem_waddr   = {pnum, bpos_reg[POS_W-1:0]};
        elem_wdata   = word_reg.transition;
        prog_we      = 1'b0;
        prog_waddr   = p_reg;
        prog_wdata   = step.prog_next;
        trav_we      = 1'b0;
        final_we     = 1'b0;
        final_waddr  = pnum;
        final_wdata  = '0;
        bp_new       = bpos_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_next   = '0;
                    state_next = S_CNT_UPD;
                end
            end

            S_CNT_UPD: begin
                state_next = S_DONE;
                case (word_reg.command)
                    CMD_CLEAR: begin
                        clear_all = 1'b1;
                        pdef_next = '0;
                        bpos_next = '0;
                    end
                    CMD_ADD: begin
                        if (pdef_reg >= FILL_W'(NUM_PATHS)) begin
                            res_next.status = ST_FULL;
                        end else begin
                            res_next.path_number = PNUM_W'(pnum);
                            if (bpos_reg >= BPOS_W'(PATH_LENGTH)) begin
                                res_next.status = ST_TOO_LONG;
                            end else begin
                                elem_we = 1'b1;
                                bp_new  = bpos_reg + 1'b1;
                                if (t_ok && (cnt_word.fill < FILL_W'(NUM_PATHS))) begin
                                    list_we        = 1'b1;
                                    cnt_we         = 1'b1;
                                    cnt_wdata.fill = cnt_word.fill + 1'b1;
                                end
                            end
                            // Closing element publishes the path
                            if (word_reg.last_element) begin
                                final_we    = 1'b1;
                                final_wdata = POS_W'(bp_new - 1'b1);
                                prog_we     = 1'b1;
                                prog_waddr  = pnum;
                                prog_wdata  = '0;
                                pdef_next   = pdef_reg + 1'b1;
                                bpos_next   = '0;
                            end else begin
                                bpos_next   = bp_new;
                            end
                        end
                    end
                    CMD_EVENT: begin
                        if (!active_reg) begin
                            res_next.status = ST_INACTIVE;
                        end else if (t_ok) begin
                            cnt_we                = 1'b1;
                            cnt_wdata.count       = inc_out;
                            res_next.count_value  = CVAL_W'(inc_out);
                            n_next                = cnt_word.fill;
                            i_next                = '0;
                            if (cnt_word.fill != '0) begin
                                list_re    = 1'b1;
                                list_raddr = {t_idx, {PATH_W{1'b0}}};
                                state_next = S_LST_CHK;
                            end
                        end
                    end
                    CMD_RD_CNT: begin
                        if (t_ok) begin
                            res_next.count_value = CVAL_W'(cnt_word.count);
                        end
                    end
                    CMD_RD_TRAV: begin
                        if (32'(word_reg.path_index) < NUM_PATHS) begin
                            res_next.count_value = CVAL_W'(trav_rd);
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // List entry in hand: fetch path elements, or skip an open path (done after the last)
            S_LST_CHK: begin
                if (lst_live) begin
                    p_next     = list_rdata_reg;
                    pos_next   = pos_clamp;
                    elem_re    = 1'b1;
                    state_next = S_ELM_CHK;
                end else if (more) begin
                    list_re = 1'b1;
                    i_next  = i_inc;
                end else begin
                    state_next = S_DONE;
                end
            end

            // Apply the match result, prefetch the next list entry if any, else done
            S_ELM_CHK: begin
                prog_we = step.prog_we;
                if (step.completed) begin
                    trav_we = 1'b1;
                    if (res_reg.paths_completed != DONE_MAX) begin
                        res_next.paths_completed = res_reg.paths_completed + 1'b1;
                    end
                end
                if (more) begin
                    list_re    = 1'b1;
                    i_next     = i_inc;
                    state_next = S_LST_CHK;
                end else begin
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            i_reg       <= '0;
            n_reg       <= '0;
            pdef_reg    <= '0;
            bpos_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            i_reg       <= i_next;
            n_reg       <= n_next;
            pdef_reg    <= pdef_next;
            bpos_reg    <= bpos_next;
            if (cfg_valid && cfg_ready) begin
                active_reg <= cfg_wdata;
            end
        end
    end

    // Progress, traversals and count valid bits: cleared by reset or clear
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_all) begin
            for (int k = 0; k < NUM_PATHS; k++) begin
                prog_reg[k] <= '0;
                trav_reg[k] <= '0;
            end
            for (int k = 0; k < NUM_TRANSITIONS; k++) begin
                cnt_vld_reg[k] <= 1'b0;
            end
        end else begin
            if (prog_we) begin
                prog_reg[prog_waddr] <= prog_wdata;
            end
            if (trav_we) begin
                trav_reg[p_reg] <= inc_out;
            end
            if (cnt_we) begin
                cnt_vld_reg[cnt_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg <= s_word;
        end
        res_reg <= res_next;
        p_reg   <= p_next;
        pos_reg <= pos_next;
        if (out_load) begin
            m_word_reg <= res_reg;
        end
        if (final_we) begin
            final_reg[final_waddr] <= final_wdata;
        end
    end

    // Count and list-fill memory
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (accept) begin
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
            cnt_rvld_reg  <= cnt_vld_reg[cnt_raddr];
        end
    end

    // Per-transition path lists
    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[list_waddr] <= list_wdata;
        end
        if (list_re) begin
            list_rdata_reg <= list_mem[list_raddr];
        end
    end

    // Path elements: two read ports, current position and first element
    always_ff @(posedge aclk) begin
        if (elem_we) begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        if (elem_re) begin
            elem_pos_rdata_reg   <= elem_mem[elem_raddr0];
            elem_first_rdata_reg <= elem_mem[elem_raddr1];
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import tpct_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 4;
    localparam int MAX_GAP      = 16;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int CFG_SETTLE   = 8;
    localparam int RANDOM_ITEMS = 550;
    localparam int SEQ_MAX      = 20;

    // Codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_BAD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BAD_LAST  = 3'd7;

    // Mirror of the tracker state, and the result words it predicts
    class tracker_scoreboard;
        count_t            trans_count[NUM_TRANSITIONS];
        logic [PATH_W-1:0] trans_list[NUM_TRANSITIONS][NUM_PATHS];
        int                list_fill[NUM_TRANSITIONS];
        logic [TRN_W-1:0]  path_elem[NUM_PATHS][PATH_LENGTH];
        int                final_pos[NUM_PATHS];
        int                progress[NUM_PATHS];
        count_t            traversals[NUM_PATHS];
        int                closed_paths;
        int                build_pos;
        bit                active;
        out_word_t         expected_words[$];
        int                errors;

        function new();
            foreach (trans_list[i, j]) trans_list[i][j] = '0;
            foreach (path_elem[i, j]) path_elem[i][j] = '0;
            foreach (final_pos[i]) final_pos[i] = 0;
            clear_tracking();
            active = 1'b0;
            errors = 0;
        endfunction

        function void clear_tracking();
            foreach (trans_count[i]) trans_count[i] = '0;
            foreach (list_fill[i]) list_fill[i] = 0;
            foreach (progress[i]) progress[i] = 0;
            foreach (traversals[i]) traversals[i] = '0;
            closed_paths = 0;
            build_pos = 0;
        endfunction

        function count_t bump(count_t v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function out_word_t predict_reply(in_word_t w);
            out_word_t r;
            int t, p, pos, done;
            r = '0;
            t = w.transition;
            done = 0;
            case (w.command)
                CMD_CLEAR: clear_tracking();
                CMD_ADD: begin
                    if (closed_paths >= NUM_PATHS) begin
                        r.status = ST_FULL;
                    end else begin
                        p = closed_paths;
                        r.path_number = PNUM_W'(p);
                        if (build_pos >= PATH_LENGTH) begin
                            r.status = ST_TOO_LONG;
                        end else begin
                            path_elem[p][build_pos] = w.transition;
                            // a full list keeps the element but does not list it again
                            if (list_fill[t] < NUM_PATHS) begin
                                trans_list[t][list_fill[t]] = PATH_W'(p);
                                list_fill[t]++;
                            end
                            build_pos++;
                        end
                        if (w.last_element) begin
                            final_pos[p] = build_pos - 1;
                            progress[p] = 0;
                            closed_paths++;
                            build_pos = 0;
                        end
                    end
                end
                CMD_EVENT: begin
                    if (!active) begin
                        r.status = ST_INACTIVE;
                    end else begin
                        trans_count[t] = bump(trans_count[t]);
                        for (int i = 0; i < list_fill[t]; i++) begin
                            p = trans_list[t][i];
                            // open path stays invisible until closed
                            if (p < closed_paths) begin
                                pos = progress[p];
                                if (path_elem[p][pos] == w.transition) begin
                                    if (pos == final_pos[p]) begin
                                        traversals[p] = bump(traversals[p]);
                                        progress[p] = 0;
                                        if (done < 31) done++;
                                    end else begin
                                        progress[p] = pos + 1;
                                    end
                                end else if (path_elem[p][0] == w.transition) begin
                                    progress[p] = 1;
                                end
                            end
                        end
                        r.count_value = trans_count[t];
                        r.paths_completed = DONE_W'(done);
                    end
                end
                CMD_RD_CNT:  r.count_value = trans_count[t];
                CMD_RD_TRAV: r.count_value = traversals[w.path_index];
                default: ;
            endcase
            return r;
        endfunction

        function void note_input(in_word_t w);
            expected_words.push_back(predict_reply(w));
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (expected_words.size() == 0) begin
                $error("result word %h arrived with nothing expected", got);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.path_number !== want.path_number) begin
                $error("path_number: expected %0d, actual %0d",
                       want.path_number, got.path_number);
                errors++;
            end
            if (got.count_value !== want.count_value) begin
                $error("count_value: expected %0d, actual %0d",
                       want.count_value, got.count_value);
                errors++;
            end
            if (got.paths_completed !== want.paths_completed) begin
                $error("paths_completed: expected %0d, actual %0d",
                       want.paths_completed, got.paths_completed);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_word;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_word;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_wdata;

    tracker_scoreboard sb;

    bit no_idle;
    bit hold_req;
    int items_sent;
    int stall_cycles;

    // Stimulus-side record of the paths defined in the current phase
    logic [TRN_W-1:0] path_seq[NUM_PATHS][SEQ_MAX];
    int               path_len[NUM_PATHS];
    int               defined;

    transition_path_coverage_tracker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Watchdog: cycles without any handshake
    initial stall_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Drive one command word and wait until it is taken
    task automatic send_cmd(logic [CMD_W-1:0] c, logic [TRN_W-1:0] t, logic l,
                            logic [PIDX_W-1:0] pi);
        in_word_t w;
        int gap;
        w.command = c;
        w.transition = t;
        w.last_element = l;
        w.path_index = pi;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(w);
        if (c <= CMD_RD_TRAV) items_sent++;
    endtask

    // Stop offering words and wait for every outstanding result
    task automatic drain_input();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_active(bit v);
        drain_input();
        repeat (CFG_SETTLE) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.active = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure, one long hold-off on request
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_word);
        end
    end

    // One random phase: define paths over a small pool, then mostly walk them
    task automatic run_phase();
        int kind, pool_n, npaths_new, len, nev, k, p, sel;
        logic [TRN_W-1:0] pool[6];
        logic [TRN_W-1:0] t;
        kind = $urandom_range(0, 9);
        no_idle = (kind == 1);
        if (kind != 2) begin
            send_cmd(CMD_CLEAR, TRN_W'($urandom), 1'($urandom), PIDX_W'($urandom));
            defined = 0;
        end
        if (kind == 4) begin
            write_active(1'b0);
        end else if (!sb.active) begin
            write_active(1'b1);
        end
        pool_n = (kind == 3) ? 1 : $urandom_range(2, 6);
        foreach (pool[i]) pool[i] = TRN_W'($urandom_range(0, NUM_TRANSITIONS - 1));

        // path definition
        case (kind)
            5:       npaths_new = 1;
            6:       npaths_new = NUM_PATHS + 1;
            default: npaths_new = $urandom_range(1, 4);
        endcase
        for (int q = 0; q < npaths_new; q++) begin
            if (kind == 5) len = $urandom_range(PATH_LENGTH + 1, PATH_LENGTH + 3);
            else if (kind == 6) len = $urandom_range(1, 2);
            else if (kind == 3) len = $urandom_range(6, 12);
            else len = $urandom_range(1, 5);
            for (int j = 0; j < len; j++) begin
                t = pool[$urandom_range(0, pool_n - 1)];
                if (defined < NUM_PATHS && j < SEQ_MAX) path_seq[defined][j] = t;
                send_cmd(CMD_ADD, t, (j == len - 1), PIDX_W'($urandom));
            end
            if (defined < NUM_PATHS) begin
                path_len[defined] = (len < SEQ_MAX) ? len : SEQ_MAX;
                defined++;
            end
        end

        // events and reads
        if (kind == 7) hold_req = 1'b1;
        nev = $urandom_range(20, 40);
        k = 0;
        while (k < nev) begin
            sel = $urandom_range(0, 99);
            if (sel < 55 && defined > 0) begin
                p = $urandom_range(0, defined - 1);
                for (int j = 0; j < path_len[p]; j++) begin
                    t = ($urandom_range(0, 9) == 0) ? pool[$urandom_range(0, pool_n - 1)]
                                                    : path_seq[p][j];
                    send_cmd(CMD_EVENT, t, 1'($urandom), PIDX_W'($urandom));
                    k++;
                end
            end else if (sel < 70) begin
                send_cmd(CMD_EVENT, pool[$urandom_range(0, pool_n - 1)],
                         1'($urandom), PIDX_W'($urandom));
                k++;
            end else if (sel < 80) begin
                t = $urandom_range(0, 1) ? pool[$urandom_range(0, pool_n - 1)]
                                         : TRN_W'($urandom);
                send_cmd(CMD_RD_CNT, t, 1'($urandom), PIDX_W'($urandom));
                k++;
            end else if (sel < 90) begin
                send_cmd(CMD_RD_TRAV, TRN_W'($urandom), 1'($urandom), PIDX_W'($urandom));
                k++;
            end else if (sel < 94) begin
                send_cmd(CMD_BAD_FIRST + CMD_W'($urandom_range(0, 2)), TRN_W'($urandom),
                         1'($urandom), PIDX_W'($urandom));
            end else if (sel < 97) begin
                send_cmd(CMD_ADD, pool[$urandom_range(0, pool_n - 1)], 1'($urandom),
                         PIDX_W'($urandom));
                k++;
            end else begin
                send_cmd(CMD_EVENT, TRN_W'($urandom), 1'($urandom), PIDX_W'($urandom));
                k++;
            end
        end

        // traversal counts of every path in the table
        for (int i = 0; i < defined; i++) begin
            send_cmd(CMD_RD_TRAV, TRN_W'($urandom), 1'($urandom), PIDX_W'(i));
        end
        drain_input();
    endtask

    // Main sequence
    initial begin
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_word = '0;
        cfg_valid = 1'b0;
        cfg_wdata = 1'b0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        items_sent = 0;
        defined = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // inactive after reset, field extremes, ignored codes
        send_cmd(CMD_EVENT, '1, 1'b1, '1);
        send_cmd(CMD_RD_CNT, '1, 1'b0, '0);
        send_cmd(CMD_RD_TRAV, '0, 1'b1, '1);
        send_cmd(CMD_BAD_LAST, '1, 1'b1, '1);
        send_cmd(CMD_BAD_FIRST, '0, 1'b0, '0);
        write_active(1'b1);

        // receiver holds off while the path words below keep coming
        hold_req = 1'b1;

        // path 0 = {0, 255}, path 1 = {255}, path 2 = {0, 0, 255} repeats a transition
        send_cmd(CMD_ADD, '0, 1'b0, '0);
        send_cmd(CMD_ADD, '1, 1'b1, '1);
        send_cmd(CMD_ADD, '1, 1'b1, '0);
        send_cmd(CMD_ADD, '0, 1'b0, '1);
        send_cmd(CMD_ADD, '0, 1'b0, '0);
        send_cmd(CMD_ADD, '1, 1'b1, '0);
        // path 3 left open: its list entry must be skipped
        send_cmd(CMD_ADD, '1, 1'b0, '0);
        send_cmd(CMD_EVENT, '0, 1'b0, '0);
        send_cmd(CMD_EVENT, '1, 1'b0, '0);
        send_cmd(CMD_EVENT, '0, 1'b1, '1);
        send_cmd(CMD_EVENT, '0, 1'b0, '0);
        send_cmd(CMD_EVENT, '1, 1'b0, '0);
        send_cmd(CMD_RD_CNT, '0, 1'b0, '0);
        send_cmd(CMD_RD_TRAV, '0, 1'b0, 4'd0);
        send_cmd(CMD_RD_TRAV, '0, 1'b0, 4'd2);
        send_cmd(CMD_RD_TRAV, '0, 1'b0, 4'd3);
        // clear forgets the paths
        send_cmd(CMD_CLEAR, '1, 1'b1, '1);
        send_cmd(CMD_EVENT, '1, 1'b0, '0);
        send_cmd(CMD_RD_TRAV, '0, 1'b0, 4'd0);
        drain_input();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) run_phase();

        no_idle = 1'b0;
        drain_input();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/tpct_pkg.sv
design/tpct_sat_inc.sv
design/tpct_step_unit.sv
design/transition_path_coverage_tracker_unit.sv
tb/tb.sv
